// File: design/rsa_public_exponent_encrypt_assert.svh
// Assertion macros shared by the RSA encryption block.
`ifndef RSA_PUBLIC_EXPONENT_ENCRYPT_ASSERT_SVH
`define RSA_PUBLIC_EXPONENT_ENCRYPT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RPE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rpe_pkg.sv
// Shared types and constants of the RSA encryption block.
`timescale 1ns / 1ps
`default_nettype none

package rpe_pkg;

	localparam int KEY_BYTES_DEF = 64;
	// Padding needs two header bytes, at least eight pad bytes and a separator.
	localparam int PAD_OVERHEAD  = 11;
	localparam logic [7:0] BLOCK_TYPE_2 = 8'h02;

	typedef enum logic [1:0] {
		OP_MODULUS = 2'd0,
		OP_MESSAGE = 2'd1,
		OP_PAD     = 2'd2,
		OP_START   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TOO_LARGE = 2'd1,
		STATUS_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_PADDING_MODE   = 2'd0,
		REG_PAYLOAD_LENGTH = 2'd1,
		REG_SQUARE_ROUNDS  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		PASS_RAW = 1'b0,
		PASS_PAD = 1'b1
	} pass_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        load_en;
		op_t         load_op;
		logic [7:0]  load_value;
		logic        clr_counts;
		logic        rd_en;
		pass_t       rd_pass;
		logic        copy_raw;
		logic        init_pow;
		logic        mm_start;
		logic        mm_sel_m;
		logic        dbl;
		logic        add;
		logic        red;
		logic        shift_a;
		logic        fin;
		logic        out_byte;
		logic        out_err;
		status_t     out_status;
		logic        out_last;
		logic [5:0]  pay_len;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic a_msb;
		logic top_ge;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: design/rpe_if.sv
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface rpe_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface rpe_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output cipher_byte, output status, output last, input ready);
	modport sink (input valid, input cipher_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// File: design/rpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/rpe_datapath.sv
// Datapath: byte stores, block builder, modular multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module rpe_datapath #(
	parameter int KEY_BYTES = rpe_pkg::KEY_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rpe_pkg::dp_cmd_t             cmd,
	input  logic [$clog2(KEY_BYTES)-1:0] rd_addr,
	output rpe_pkg::dp_stat_t            stat,
	output logic [7:0]                   cipher_byte,
	output logic [1:0]                   status,
	output logic                         last
);

	import rpe_pkg::*;

	localparam int AW = $clog2(KEY_BYTES);
	localparam int NB = KEY_BYTES * 8;
	localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_BYTES - 1);
	localparam logic [7:0] HDR_LIMIT = 8'(KEY_BYTES - 2);

	logic [AW-1:0] mod_cnt_q, msg_cnt_q, pad_cnt_q;
	logic          rd_en_s1;
	pass_t         rd_pass_s1;
	logic [AW-1:0] rd_addr_s1;
	logic [7:0]    mod_rd, blk_rd, pad_rd;
	logic          mod_we, blk_we, pad_we, blk_wr;
	logic [AW-1:0] blk_waddr;
	logic [7:0]    blk_wdata;
	logic [7:0]    pos8, len8, lim8, pad_byte;
	logic          take_pay;
	logic [NB-1:0] n_q, m_q, p_q, a_q, b_val;
	logic [NB:0]   acc_q, sub_in, red_res;
	logic [NB+1:0] diff;
	logic          bsel_q;

	function automatic logic [AW-1:0] next_cnt(input logic [AW-1:0] c);
		next_cnt = (c == LAST_ADDR) ? '0 : c + AW'(1);
	endfunction

	// Load positions wrap after the last byte of the key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q  <= '0;
			msg_cnt_q  <= '0;
			pad_cnt_q  <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (mod_we) begin
				mod_cnt_q <= next_cnt(mod_cnt_q);
			end
			if (cmd.clr_counts) begin
				msg_cnt_q <= '0;
				pad_cnt_q <= '0;
			end else begin
				if (cmd.load_en && cmd.load_op == OP_MESSAGE) begin
					msg_cnt_q <= next_cnt(msg_cnt_q);
				end
				if (pad_we) begin
					pad_cnt_q <= next_cnt(pad_cnt_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_pass_s1 <= cmd.rd_pass;
		rd_addr_s1 <= rd_addr;
	end

	assign mod_we    = cmd.load_en && cmd.load_op == OP_MODULUS;
	assign pad_we    = cmd.load_en && cmd.load_op == OP_PAD;
	assign blk_wr    = rd_en_s1 && rd_pass_s1 == PASS_PAD;
	assign blk_we    = (cmd.load_en && cmd.load_op == OP_MESSAGE) || blk_wr;
	assign blk_waddr = blk_wr ? rd_addr_s1 : msg_cnt_q;
	assign blk_wdata = blk_wr ? pad_byte : cmd.load_value;

	rpe_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_mod_ram (
		.clk(clk), .we(mod_we), .waddr(mod_cnt_q), .wdata(cmd.load_value),
		.raddr(rd_addr), .rdata(mod_rd)
	);

	rpe_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_blk_ram (
		.clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
		.raddr(rd_addr), .rdata(blk_rd)
	);

	rpe_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_pad_ram (
		.clk(clk), .we(pad_we), .waddr(pad_cnt_q), .wdata(cmd.load_value),
		.raddr(rd_addr), .rdata(pad_rd)
	);

	// Type 2 block byte at position pos8. The payload comes from the top of a_q,
	// which holds the raw message bytes read in the first pass.
	always_comb begin
		pos8     = 8'(rd_addr_s1);
		len8     = 8'(cmd.pay_len);
		lim8     = HDR_LIMIT - len8;
		take_pay = 1'b0;
		if (pos8 == 8'd0) begin
			pad_byte = 8'd0;
		end else if (pos8 == 8'd1) begin
			pad_byte = BLOCK_TYPE_2;
		end else if (pos8 <= lim8) begin
			pad_byte = (pad_rd != 8'd0) ? pad_rd : pos8 + 8'd1;
		end else if (pos8 == lim8 + 8'd1) begin
			pad_byte = 8'd0;
		end else begin
			pad_byte = a_q[NB-1 -: 8];
			take_pay = blk_wr;
		end
	end

	// One conditional subtraction of the modulus, after doubling or after an add.
	assign b_val   = bsel_q ? m_q : p_q;
	assign sub_in  = cmd.dbl ? {acc_q[NB-1:0], 1'b0} : acc_q;
	assign diff    = {1'b0, sub_in} - {2'b00, n_q};
	assign red_res = diff[NB+1] ? sub_in : diff[NB:0];

	always_ff @(posedge clk) begin
		if (rd_en_s1 && rd_pass_s1 == PASS_RAW) begin
			n_q <= {n_q[NB-9:0], mod_rd};
			a_q <= {a_q[NB-9:0], blk_rd};
		end else if (blk_wr) begin
			m_q <= {m_q[NB-9:0], pad_byte};
			if (take_pay) begin
				a_q <= {a_q[NB-9:0], 8'd0};
			end
		end else if (cmd.copy_raw) begin
			m_q <= a_q;
		end else if (cmd.init_pow) begin
			p_q <= m_q;
		end else if (cmd.mm_start) begin
			a_q    <= p_q;
			acc_q  <= '0;
			bsel_q <= cmd.mm_sel_m;
		end else if (cmd.add) begin
			acc_q <= acc_q + {1'b0, b_val};
		end else if (cmd.dbl || cmd.red) begin
			acc_q <= red_res;
			if (cmd.shift_a) begin
				a_q <= {a_q[NB-2:0], 1'b0};
			end
		end else if (cmd.fin) begin
			p_q <= acc_q[NB-1:0];
		end else if (cmd.out_byte) begin
			p_q <= {p_q[NB-9:0], 8'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_byte) begin
			cipher_byte <= p_q[NB-1 -: 8];
			status      <= STATUS_OK;
			last        <= cmd.out_last;
		end else if (cmd.out_err) begin
			cipher_byte <= 8'd0;
			status      <= cmd.out_status;
			last        <= 1'b1;
		end
	end

	assign stat.a_msb  = a_q[NB-1];
	assign stat.top_ge = m_q[NB-1 -: 8] >= n_q[NB-1 -: 8];

endmodule

`default_nettype wire

// File: design/rpe_ctrl.sv
// Controller: configuration registers, sequencing state machine, result valid.
`timescale 1ns / 1ps
`default_nettype none

module rpe_ctrl #(
	parameter int KEY_BYTES = rpe_pkg::KEY_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [1:0]                   wr_index,
	input  logic [5:0]                   wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_operation,
	input  logic [7:0]                   in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rpe_pkg::dp_cmd_t             dp_cmd,
	output logic [$clog2(KEY_BYTES)-1:0] rd_addr,
	input  rpe_pkg::dp_stat_t            stat
);

	import rpe_pkg::*;

	localparam int AW = $clog2(KEY_BYTES);
	localparam int NB = KEY_BYTES * 8;
	localparam int BW = $clog2(NB);
	localparam logic [AW:0]   IDX_END  = (AW+1)'(KEY_BYTES);
	localparam logic [AW:0]   IDX_LAST = (AW+1)'(KEY_BYTES - 1);
	localparam logic [BW-1:0] BIT_LAST = BW'(NB - 1);
	localparam logic [6:0]    LEN_MAX  = 7'(KEY_BYTES - PAD_OVERHEAD);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RAW   = 12'b0000_0000_0010,
		S_PAD   = 12'b0000_0000_0100,
		S_COPY  = 12'b0000_0000_1000,
		S_CHECK = 12'b0000_0001_0000,
		S_SETUP = 12'b0000_0010_0000,
		S_DBL   = 12'b0000_0100_0000,
		S_ADD   = 12'b0000_1000_0000,
		S_RED   = 12'b0001_0000_0000,
		S_FIN   = 12'b0010_0000_0000,
		S_EMIT  = 12'b0100_0000_0000,
		S_ERR   = 12'b1000_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [AW:0]   idx_q, idx_d;
	logic [BW-1:0] bit_q, bit_d;
	logic [4:0]    rem_q, rem_d;
	status_t       err_q, err_d;
	logic          out_valid_q, load_out;
	logic          mode_q;
	logic [5:0]    len_q;
	logic [4:0]    rounds_q;
	logic          accept, slot_free, len_bad, bit_done;

	assign in_ready  = state_q == S_IDLE;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign len_bad   = {1'b0, len_q} > LEN_MAX;
	assign bit_done  = bit_q == BIT_LAST;
	assign out_valid = out_valid_q;
	assign rd_addr   = idx_q[AW-1:0];

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.load_op    = op_t'(in_operation);
		dp_cmd.load_value = in_value;
		dp_cmd.pay_len    = len_q;
		dp_cmd.out_status = err_q;
		state_d  = state_q;
		idx_d    = idx_q;
		bit_d    = bit_q;
		rem_d    = rem_q;
		err_d    = err_q;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op_t'(in_operation) != OP_START) begin
						dp_cmd.load_en = 1'b1;
					end else begin
						dp_cmd.clr_counts = 1'b1;
						idx_d = '0;
						if (mode_q && len_bad) begin
							err_d   = STATUS_TOO_LONG;
							state_d = S_ERR;
						end else begin
							state_d = S_RAW;
						end
					end
				end
			end
			S_RAW, S_PAD: begin
				// The read issued at the last address lands in the next cycle, while idx_q holds IDX_END.
				dp_cmd.rd_pass = (state_q == S_PAD) ? PASS_PAD : PASS_RAW;
				if (idx_q != IDX_END) begin
					dp_cmd.rd_en = 1'b1;
					idx_d = idx_q + (AW+1)'(1);
				end else begin
					idx_d = '0;
					if (state_q == S_PAD) begin
						state_d = S_CHECK;
					end else begin
						state_d = mode_q ? S_PAD : S_COPY;
					end
				end
			end
			S_COPY: begin
				dp_cmd.copy_raw = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.top_ge) begin
					err_d   = STATUS_TOO_LARGE;
					state_d = S_ERR;
				end else begin
					dp_cmd.init_pow = 1'b1;
					rem_d   = rounds_q;
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				// Squarings first; the last product is by the message itself.
				dp_cmd.mm_start = 1'b1;
				dp_cmd.mm_sel_m = rem_q == 5'd0;
				bit_d   = '0;
				state_d = S_DBL;
			end
			S_DBL: begin
				dp_cmd.dbl = 1'b1;
				if (stat.a_msb) begin
					state_d = S_ADD;
				end else begin
					dp_cmd.shift_a = 1'b1;
					if (bit_done) begin
						state_d = S_FIN;
					end else begin
						bit_d = bit_q + BW'(1);
					end
				end
			end
			S_ADD: begin
				dp_cmd.add = 1'b1;
				state_d = S_RED;
			end
			S_RED: begin
				dp_cmd.red     = 1'b1;
				dp_cmd.shift_a = 1'b1;
				if (bit_done) begin
					state_d = S_FIN;
				end else begin
					bit_d   = bit_q + BW'(1);
					state_d = S_DBL;
				end
			end
			S_FIN: begin
				dp_cmd.fin = 1'b1;
				if (rem_q == 5'd0) begin
					idx_d   = '0;
					state_d = S_EMIT;
				end else begin
					rem_d   = rem_q - 5'd1;
					state_d = S_SETUP;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					dp_cmd.out_byte = 1'b1;
					dp_cmd.out_last = idx_q == IDX_LAST;
					load_out = 1'b1;
					if (idx_q == IDX_LAST) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + (AW+1)'(1);
					end
				end
			end
			S_ERR: begin
				if (slot_free) begin
					dp_cmd.out_err  = 1'b1;
					dp_cmd.out_last = 1'b1;
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			bit_q       <= '0;
			rem_q       <= '0;
			err_q       <= STATUS_OK;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b1;
			len_q       <= 6'd0;
			rounds_q    <= 5'd16;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			bit_q   <= bit_d;
			rem_q   <= rem_d;
			err_q   <= err_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				unique case (wr_index)
					REG_PADDING_MODE:   mode_q   <= wr_data[0];
					REG_PAYLOAD_LENGTH: len_q    <= wr_data;
					REG_SQUARE_ROUNDS:  rounds_q <= wr_data[4:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: design/rsa_public_exponent_encrypt.sv
// Top level of the RSA encryption block with exponent two to the k plus one.
// Usage: modulus, message and pad bytes arrive on the cmd channel as transactions
// with operation 0, 1 and 2, most significant byte first, one per cycle; each
// load writes its store at a running position that wraps after KEY_BYTES bytes.
// A start transaction (operation 3) rewinds the message and pad positions and runs
// one encryption. While it runs cmd.ready stays low.
// The run reads the modulus and message stores, and in padding mode then builds the
// type 2 block in a second pass. Each of the k + 1 modular multiplications walks
// the 8 * KEY_BYTES bits of one operand with a shared doubling and conditional
// subtraction unit: each bit is doubled and reduced, and a one bit also adds the
// multiplicand and reduces again, after a setup step and before a write-back step.
// The ciphertext then leaves on the rsp channel as KEY_BYTES transactions, most
// significant byte first, with last on the final one.
// In padding mode a payload longer than KEY_BYTES - 11, or in either mode a block
// whose top byte is not below the modulus top byte, ends the run early with a single
// rsp transaction carrying the status code, a zero byte and last.
// The rsp channel has its own output register: a stalled receiver only holds the
// run in its output phase, and the next loads are taken once the last result sits
// in that register. Reset clears positions and control and restores configuration
// defaults; the byte stores have no reset. The user must write configuration via
// wr_en, wr_index and wr_data only while the block idles; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
`include "rsa_public_exponent_encrypt_assert.svh"

module rsa_public_exponent_encrypt #(
	parameter int KEY_BYTES = rpe_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rpe_cmd_if.sink    cmd,
	rpe_rsp_if.source  rsp,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [5:0] wr_data
);

	import rpe_pkg::*;

	localparam int AW = $clog2(KEY_BYTES);

	dp_cmd_t       dp_cmd;
	dp_stat_t      dp_stat;
	logic [AW-1:0] rd_addr;

	// The controller sequences the run; the datapath holds all stores and operands.
	rpe_ctrl #(.KEY_BYTES(KEY_BYTES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (cmd.valid),
		.in_ready     (cmd.ready),
		.in_operation (cmd.operation),
		.in_value     (cmd.value),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.dp_cmd       (dp_cmd),
		.rd_addr      (rd_addr),
		.stat         (dp_stat)
	);

	rpe_datapath #(.KEY_BYTES(KEY_BYTES)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.rd_addr     (rd_addr),
		.stat        (dp_stat),
		.cipher_byte (rsp.cipher_byte),
		.status      (rsp.status),
		.last        (rsp.last)
	);

	// A start transaction always makes the block busy in the next cycle.
	`RPE_ASSERT_NEXT(a_start_busy, cmd.valid && cmd.ready && cmd.operation == OP_START, !cmd.ready, "start did not leave idle")
	// Byte loads never leave the idle state.
	`RPE_ASSERT_NEXT(a_load_idle, cmd.valid && cmd.ready && cmd.operation != OP_START, cmd.ready, "load left idle")
	// An error result is a single transaction with a zero byte.
	`RPE_ASSERT_IMPLIES(a_err_last, rsp.valid && rsp.status != STATUS_OK, rsp.last && rsp.cipher_byte == 8'd0, "error result malformed")

endmodule

`default_nettype wire

// File: tb/sv/tb_rsa_public_exponent_encrypt.sv
// Self-checking testbench for the RSA encryption block with exponent two to the k plus one.
`timescale 1ns / 1ps

module tb_rsa_public_exponent_encrypt;
	import rpe_pkg::*;

	localparam int KB = KEY_BYTES_DEF;
	localparam int RANDOM_ITEMS = 160;
	localparam int QUIET_FROM = 130;

	// One ciphertext byte or one status transaction, as the rsp channel carries it.
	typedef struct {
		logic [7:0] cipher;
		status_t    status;
		logic       last;
	} cipher_result_t;

	// A row of the directed part: either a register write or a cmd transaction.
	// Where typed is set, the single status transaction is written out by hand.
	typedef struct {
		bit         is_cfg;
		logic [1:0] code;
		logic [7:0] data;
		bit         typed;
		status_t    want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [5:0] wr_data;

	rpe_cmd_if cmd_ch ();
	rpe_rsp_if rsp_ch ();

	rsa_public_exponent_encrypt dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow copy of the block's stores, positions and registers.
	logic [7:0] modulus_mem [KB];
	logic [7:0] message_mem [KB];
	logic [7:0] pad_mem [KB];
	int modulus_pos, message_pos, pad_pos;
	bit pad_mode;
	int pay_len;
	int rounds;

	cipher_result_t pending_results [$];

	int failures = 0;
	int items_sent = 0;
	int starts_sent = 0;
	int results_seen = 0;
	int status_seen = 0;
	bit quiet_tail = 0;
	int stall_left = 0;

	// The directed part. Status transactions that follow straight from the
	// registers or from a top byte compare are typed in; the rest is predicted.
	dir_row_t dir_rows [0:25] = '{
		'{1'b1, REG_PAYLOAD_LENGTH, 8'd54, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b1, STATUS_TOO_LONG},
		'{1'b1, REG_PAYLOAD_LENGTH, 8'd63, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'hff, 1'b1, STATUS_TOO_LONG},
		'{1'b1, REG_PAYLOAD_LENGTH, 8'd53, 1'b0, STATUS_OK},
		'{1'b1, REG_SQUARE_ROUNDS, 8'd0, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b0, STATUS_OK},
		'{1'b1, REG_PAYLOAD_LENGTH, 8'd0, 1'b0, STATUS_OK},
		'{1'b1, REG_SQUARE_ROUNDS, 8'd1, 1'b0, STATUS_OK},
		'{1'b0, OP_PAD, 8'h00, 1'b0, STATUS_OK},
		'{1'b0, OP_PAD, 8'h00, 1'b0, STATUS_OK},
		'{1'b0, OP_PAD, 8'h00, 1'b0, STATUS_OK},
		'{1'b0, OP_PAD, 8'hff, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b0, STATUS_OK},
		'{1'b1, REG_PADDING_MODE, 8'd0, 1'b0, STATUS_OK},
		'{1'b1, REG_SQUARE_ROUNDS, 8'd31, 1'b0, STATUS_OK},
		'{1'b0, OP_MESSAGE, 8'h00, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b0, STATUS_OK},
		'{1'b1, REG_SQUARE_ROUNDS, 8'd16, 1'b0, STATUS_OK},
		'{1'b0, OP_MESSAGE, 8'hff, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b1, STATUS_TOO_LARGE},
		'{1'b0, OP_MODULUS, 8'h00, 1'b0, STATUS_OK},
		'{1'b0, OP_MESSAGE, 8'h7f, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b1, STATUS_TOO_LARGE},
		'{1'b1, REG_PADDING_MODE, 8'd1, 1'b0, STATUS_OK},
		'{1'b0, OP_START, 8'h00, 1'b1, STATUS_TOO_LARGE}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A generous ceiling: even every start at the largest round count fits well inside.
	initial begin
		#400_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic push_status(status_t st);
		pending_results.push_back('{8'h00, st, 1'b1});
	endtask

	// Updates the shadow state for one accepted cmd transaction and queues the
	// ciphertext, or the status transaction, that a start produces.
	task automatic predict_item(op_t op, logic [7:0] val);
		logic [7:0] blk [KB];
		logic [1023:0] n_w, m_w, acc;
		int i;
		case (op)
			OP_MODULUS: begin
				modulus_mem[modulus_pos] = val;
				modulus_pos = (modulus_pos + 1) % KB;
			end
			OP_MESSAGE: begin
				message_mem[message_pos] = val;
				message_pos = (message_pos + 1) % KB;
			end
			OP_PAD: begin
				pad_mem[pad_pos] = val;
				pad_pos = (pad_pos + 1) % KB;
			end
			default: begin
				message_pos = 0;
				pad_pos = 0;
				if (pad_mode) begin
					if (pay_len > KB - PAD_OVERHEAD) begin
						push_status(STATUS_TOO_LONG);
						return;
					end
					// Type 2 block: header, nonzero padding, separator, payload.
					blk[0] = 8'h00;
					blk[1] = BLOCK_TYPE_2;
					for (i = 2; i <= KB - 2 - pay_len; i++)
						blk[i] = (pad_mem[i] != 8'h00) ? pad_mem[i] : 8'(i + 1);
					blk[KB - 1 - pay_len] = 8'h00;
					for (i = 0; i < pay_len; i++)
						blk[KB - pay_len + i] = message_mem[i];
					message_mem = blk;
				end
				if (message_mem[0] >= modulus_mem[0]) begin
					push_status(STATUS_TOO_LARGE);
					return;
				end
				n_w = '0;
				m_w = '0;
				for (i = 0; i < KB; i++) begin
					n_w = (n_w << 8) | modulus_mem[i];
					m_w = (m_w << 8) | message_mem[i];
				end
				acc = m_w;
				for (i = 0; i < rounds; i++)
					acc = (acc * acc) % n_w;
				acc = (acc * m_w) % n_w;
				for (i = 0; i < KB; i++)
					pending_results.push_back('{acc[8 * (KB - 1 - i) +: 8], STATUS_OK,
						(i == KB - 1)});
			end
		endcase
	endtask

	// Offers one transaction, with an occasional idle burst in front of it, and
	// predicts it once it is taken. This task only lowers the valid line for a burst.
	task automatic send_item(op_t op, logic [7:0] val, bit typed = 0,
		status_t want = STATUS_OK);
		int gap;
		int queued;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.value <= val;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		if (op == OP_START)
			starts_sent++;
		queued = pending_results.size();
		predict_item(op, val);
		if (typed) begin
			while (pending_results.size() > queued)
				void'(pending_results.pop_back());
			push_status(want);
		end
	endtask

	// Stops offering transactions until every queued result has come back, then
	// waits for a trailing load to settle.
	task automatic drain_block();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [5:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PADDING_MODE: pad_mode = data[0];
			REG_PAYLOAD_LENGTH: pay_len = data;
			REG_SQUARE_ROUNDS: rounds = data[4:0];
			default: ;
		endcase
	endtask

	// Brings the modulus position back to the top byte, then loads a whole modulus.
	task automatic load_modulus(logic [7:0] top);
		int i;
		while (modulus_pos != 0)
			send_item(OP_MODULUS, 8'($urandom()));
		send_item(OP_MODULUS, top);
		for (i = 1; i < KB; i++)
			send_item(OP_MODULUS, 8'($urandom()));
	endtask

	// The receiver stalls in random bursts, and not at all at the end.
	always @(posedge clk) begin
		if (!quiet_tail && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Every rsp transaction is matched against the oldest queued expectation.
	always @(posedge clk) begin : result_check
		cipher_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: cipher_byte %02h status %0d last %0b",
					rsp_ch.cipher_byte, rsp_ch.status, rsp_ch.last);
				failures++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (want.status != STATUS_OK)
					status_seen++;
				if (rsp_ch.cipher_byte !== want.cipher) begin
					$error("cipher_byte: expected %02h, got %02h", want.cipher,
						rsp_ch.cipher_byte);
					failures++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					failures++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, rsp_ch.last);
					failures++;
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		int random_start;
		int count;
		int sequences;
		logic [7:0] byte_val;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_MODULUS;
		cmd_ch.value = 8'h00;
		rsp_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_PADDING_MODE;
		wr_data = '0;
		modulus_pos = 0;
		message_pos = 0;
		pad_pos = 0;
		pad_mode = PASS_PAD;
		pay_len = 0;
		rounds = 16;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every store entry that a start can read is written before the first start.
		load_modulus(8'hff);
		for (i = 0; i < KB; i++)
			send_item(OP_PAD, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
		for (i = 0; i < KB; i++)
			send_item(OP_MESSAGE, 8'($urandom()));

		// Directed part: payload length limits, round count extremes, pad zeros that
		// get replaced, and both top byte checks including a zero modulus top byte.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain_block();
				write_reg(reg_idx_t'(dir_rows[i].code), dir_rows[i].data[5:0]);
			end else begin
				send_item(op_t'(dir_rows[i].code), dir_rows[i].data, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end
		load_modulus(8'hff);

		// Random part: mostly well-formed runs of loads followed by a start, with
		// stray loads mixed in and the registers changed between runs.
		random_start = items_sent;
		sequences = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			quiet_tail = (items_sent - random_start >= QUIET_FROM);
			if ($urandom_range(0, 3) == 0) begin
				drain_block();
				write_reg(REG_PADDING_MODE,
					6'(($urandom_range(0, 9) < 7) ? PASS_PAD : PASS_RAW));
				write_reg(REG_PAYLOAD_LENGTH, ($urandom_range(0, 9) == 0) ?
					6'($urandom_range(54, 63)) : 6'($urandom_range(0, 53)));
				case ($urandom_range(0, 19))
					0: write_reg(REG_SQUARE_ROUNDS, 6'd16);
					1: write_reg(REG_SQUARE_ROUNDS, 6'd0);
					default: write_reg(REG_SQUARE_ROUNDS, 6'($urandom_range(1, 3)));
				endcase
			end
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 3))
					0: byte_val = 8'($urandom());
					1: byte_val = 8'h80;
					default: byte_val = 8'hff;
				endcase
				load_modulus(byte_val);
			end
			count = $urandom_range(0, 6);
			for (i = 0; i < count; i++)
				send_item(OP_MESSAGE, 8'($urandom()));
			count = $urandom_range(0, 4);
			for (i = 0; i < count; i++)
				send_item(OP_PAD, ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom()));
			if ($urandom_range(0, 9) == 0)
				send_item(op_t'($urandom_range(0, 2)), 8'($urandom()));
			// Once early on, and at random, the start is held back until the block has gone quiet.
			if (sequences == 2 || $urandom_range(0, 15) == 0)
				drain_block();
			send_item(OP_START, 8'($urandom()));
			sequences++;
		end

		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			failures++;
		end
		$display("Ran %0d transactions with %0d encryptions; %0d results checked, %0d of them",
			items_sent, starts_sent, results_seen, status_seen);
		$display("status reports, across raw and padded blocks and several round counts.");
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
